FILE: design/rtss_pkg.sv
// Package for the resistive touch scan sequencer.
// Types, register indexes, result codes and reset values shared by all modules.
// No dependencies.
package rtss_pkg;

    localparam int ADC_W           = 12;
    localparam int ADC_BITS_DEFAULT = 12;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int GAP_W           = 12;
    localparam int DELAY_W         = 16;
    localparam int COORD_W         = 16;
    localparam int PRESS_W         = 13;

    localparam logic [COORD_W-1:0] PEN_UP_COORD = 16'hFFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_DOWN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_UP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION = 3'd5;

    // register reset values
    localparam logic [GAP_W-1:0]   RST_PEN_DOWN   = 12'd400;
    localparam logic [GAP_W-1:0]   RST_PEN_UP     = 12'd2000;
    localparam logic [DELAY_W-1:0] RST_SETTLE     = 16'd2;
    localparam logic [DELAY_W-1:0] RST_IDLE       = 16'd100;
    localparam logic [DELAY_W-1:0] RST_TRANSITION = 16'd20;

    // sample kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_TOUCH  = 2'd1;
    localparam logic [1:0] KIND_PEN_UP = 2'd2;

    // panel drive modes
    localparam logic [1:0] DRIVE_PRESSURE = 2'd0;
    localparam logic [1:0] DRIVE_X        = 2'd1;
    localparam logic [1:0] DRIVE_Y        = 2'd2;

    // ADC channels
    localparam logic CHAN_NINE  = 1'b0;
    localparam logic CHAN_EIGHT = 1'b1;

    typedef enum logic [3:0] {
        STEP_PRESS1 = 4'd0,
        STEP_PRESS2 = 4'd1,
        STEP_X      = 4'd2,
        STEP_Y      = 4'd3,
        STEP_RESET  = 4'd9
    } t_step;

    typedef struct packed {
        logic               enable;
        logic [GAP_W-1:0]   pen_down_gap;
        logic [GAP_W-1:0]   pen_up_gap;
        logic [DELAY_W-1:0] settle_delay;
        logic [DELAY_W-1:0] idle_delay;
        logic [DELAY_W-1:0] transition_delay;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         sample_kind;
        logic [COORD_W-1:0] x_position;
        logic [COORD_W-1:0] y_position;
        logic [PRESS_W-1:0] pressure;
        logic [1:0]         drive_mode;
        logic               next_channel;
        logic [DELAY_W-1:0] start_delay;
    } t_result;

endpackage

FILE: design/rtss_cfg.sv
// Configuration register bank of the touch scan sequencer.
// Depends on rtss_pkg.
module rtss_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rtss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rtss_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output rtss_pkg::t_cfg                     o_cfg
);

    rtss_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable           <= 1'b0;
            r_cfg.pen_down_gap     <= rtss_pkg::RST_PEN_DOWN;
            r_cfg.pen_up_gap       <= rtss_pkg::RST_PEN_UP;
            r_cfg.settle_delay     <= rtss_pkg::RST_SETTLE;
            r_cfg.idle_delay       <= rtss_pkg::RST_IDLE;
            r_cfg.transition_delay <= rtss_pkg::RST_TRANSITION;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rtss_pkg::CFG_ENABLE:     r_cfg.enable <= i_cfg_data[0];
                rtss_pkg::CFG_PEN_DOWN:
                    r_cfg.pen_down_gap <= i_cfg_data[rtss_pkg::GAP_W-1:0];
                rtss_pkg::CFG_PEN_UP:
                    r_cfg.pen_up_gap <= i_cfg_data[rtss_pkg::GAP_W-1:0];
                rtss_pkg::CFG_SETTLE:     r_cfg.settle_delay <= i_cfg_data;
                rtss_pkg::CFG_IDLE:       r_cfg.idle_delay <= i_cfg_data;
                rtss_pkg::CFG_TRANSITION: r_cfg.transition_delay <= i_cfg_data;
                default: ;  // unlisted index: dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/rtss_step.sv
// Scan step state machine: pressure check, X and Y scan, pen-up tracking.
// Forms one result per handled ADC item. Depends on rtss_pkg.
module rtss_step #(
    parameter int ADC_BITS = rtss_pkg::ADC_BITS_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  logic [rtss_pkg::ADC_W-1:0]     i_adc_value,
    input  rtss_pkg::t_cfg                 i_cfg,
    output rtss_pkg::t_result              o_result
);

    // readings wider than the input field carry no extra bits
    localparam int VBITS = (ADC_BITS < rtss_pkg::ADC_W) ? ADC_BITS : rtss_pkg::ADC_W;
    localparam int PW    = rtss_pkg::PRESS_W;

    rtss_pkg::t_step    r_step, n_step;
    logic [VBITS-1:0]   r_first, n_first;
    logic [VBITS-1:0]   r_second, n_second;
    logic [VBITS-1:0]   r_held_x, n_held_x;
    logic               r_lifted, n_lifted;

    logic [VBITS-1:0]   v;
    logic [PW-1:0]      sum_down, sum_up, sum_press;
    logic [PW-1:0]      press;

    assign v = i_adc_value[VBITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= rtss_pkg::STEP_RESET;
            r_first  <= '0;
            r_second <= '0;
            r_held_x <= '0;
            r_lifted <= 1'b1;
        end else if (i_take) begin
            r_step   <= n_step;
            r_first  <= n_first;
            r_second <= n_second;
            r_held_x <= n_held_x;
            r_lifted <= n_lifted;
        end
    end

    always_comb begin
        sum_down  = PW'(i_cfg.pen_down_gap) + PW'(v);
        sum_up    = PW'(i_cfg.pen_up_gap) + PW'(v);
        sum_press = PW'(i_cfg.pen_down_gap) + PW'(r_second);
        // max sum is below 8191, so no saturation is ever reached
        press     = (sum_press > PW'(r_first)) ? (sum_press - PW'(r_first)) : '0;

        n_step   = r_step;
        n_first  = r_first;
        n_second = r_second;
        n_held_x = r_held_x;
        n_lifted = r_lifted;

        o_result.sample_kind  = rtss_pkg::KIND_NONE;
        o_result.x_position   = '0;
        o_result.y_position   = '0;
        o_result.pressure     = '0;
        o_result.drive_mode   = rtss_pkg::DRIVE_PRESSURE;
        o_result.next_channel = rtss_pkg::CHAN_NINE;
        o_result.start_delay  = '0;

        case (r_step)
            rtss_pkg::STEP_PRESS1: begin
                n_first = v;
                n_step  = rtss_pkg::STEP_PRESS2;
                o_result.next_channel = rtss_pkg::CHAN_EIGHT;
            end
            rtss_pkg::STEP_PRESS2: begin
                n_second = v;
                if (sum_down > PW'(r_first)) begin
                    n_step = rtss_pkg::STEP_X;
                    o_result.drive_mode  = rtss_pkg::DRIVE_X;
                    o_result.start_delay = i_cfg.settle_delay;
                end else if (sum_up < PW'(r_first)) begin
                    n_step = rtss_pkg::STEP_PRESS1;
                    o_result.start_delay = i_cfg.idle_delay;
                    if (!r_lifted) begin
                        n_lifted = 1'b1;
                        o_result.sample_kind = rtss_pkg::KIND_PEN_UP;
                        o_result.x_position  = rtss_pkg::PEN_UP_COORD;
                        o_result.y_position  = rtss_pkg::PEN_UP_COORD;
                    end
                end else begin
                    // dead band: reading dropped
                    n_step = rtss_pkg::STEP_PRESS1;
                    o_result.start_delay = i_cfg.transition_delay;
                end
            end
            rtss_pkg::STEP_X: begin
                n_held_x = v;
                n_step   = rtss_pkg::STEP_Y;
                o_result.drive_mode   = rtss_pkg::DRIVE_Y;
                o_result.next_channel = rtss_pkg::CHAN_EIGHT;
                o_result.start_delay  = i_cfg.settle_delay;
            end
            rtss_pkg::STEP_Y: begin
                n_lifted = 1'b0;
                n_step   = rtss_pkg::STEP_PRESS1;
                o_result.sample_kind = rtss_pkg::KIND_TOUCH;
                o_result.x_position  = rtss_pkg::COORD_W'(r_held_x);
                o_result.y_position  = rtss_pkg::COORD_W'(v);
                o_result.pressure    = press;
                o_result.start_delay = i_cfg.settle_delay;
            end
            default: begin
                n_step = rtss_pkg::STEP_PRESS1;
                o_result.start_delay = i_cfg.idle_delay;
            end
        endcase
    end

endmodule

FILE: design/rtss_out_buf.sv
// Two-entry output buffer: result register plus skid entry.
// Stall toward the input side comes from the skid flop only. Depends on rtss_pkg.
module rtss_out_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rtss_pkg::t_result    i_data,
    output logic                 o_full,
    output logic                 o_valid,
    input  logic                 i_stall,
    output rtss_pkg::t_result    o_data
);

    logic              r_main_valid, n_main_valid;
    logic              r_skid_valid, n_skid_valid;
    rtss_pkg::t_result r_main, n_main;
    rtss_pkg::t_result r_skid, n_skid;
    logic              pop;

    assign pop = r_main_valid && !i_stall;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (pop || !r_main_valid) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid_valid = i_push;
                n_skid       = i_data;
            end else begin
                n_main_valid = i_push;
                n_main       = i_data;
            end
        end else if (i_push) begin
            // head held by downstream: park the item
            n_skid_valid = 1'b1;
            n_skid       = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

endmodule

FILE: design/resistive_touch_scan_sequencer.sv
// Four-wire resistive touch scan sequencer, top level.
// Results are registered in the output buffer. Throughput: one item per
// cycle while the buffer is not full; the step logic is a single pass, and
// the two-entry buffer keeps input accepted while one result waits.
// Reset (synchronous, active low): step invalid, levels 0, pen lifted,
// registers to their reset values, output buffer empty. Uses rtss_pkg.
module resistive_touch_scan_sequencer #(
    parameter int ADC_BITS = rtss_pkg::ADC_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rtss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rtss_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [rtss_pkg::ADC_W-1:0]        i_adc_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_sample_kind,
    output logic [rtss_pkg::COORD_W-1:0]      o_x_position,
    output logic [rtss_pkg::COORD_W-1:0]      o_y_position,
    output logic [rtss_pkg::PRESS_W-1:0]      o_pressure,
    output logic [1:0]                        o_drive_mode,
    output logic                              o_next_channel,
    output logic [rtss_pkg::DELAY_W-1:0]      o_start_delay
);

    rtss_pkg::t_cfg    cfg;
    rtss_pkg::t_result step_res;
    rtss_pkg::t_result out_res;
    logic              buf_full;
    logic              take;

    // items taken while disabled leave no trace
    assign take       = i_in_valid && !buf_full && cfg.enable;
    assign o_in_stall = buf_full;

    rtss_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rtss_step #(
        .ADC_BITS (ADC_BITS)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_adc_value (i_adc_value),
        .i_cfg       (cfg),
        .o_result    (step_res)
    );

    rtss_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (step_res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_res)
    );

    assign o_sample_kind  = out_res.sample_kind;
    assign o_x_position   = out_res.x_position;
    assign o_y_position   = out_res.y_position;
    assign o_pressure     = out_res.pressure;
    assign o_drive_mode   = out_res.drive_mode;
    assign o_next_channel = out_res.next_channel;
    assign o_start_delay  = out_res.start_delay;

endmodule
